/* sv/jbt_pkg.sv */
// Shared types and codes for the JSON byte tokenizer.
`default_nettype none

package jbt_pkg;

   // Token kinds carried on the result channel.
   localparam logic [3:0] KIND_STRING = 4'd0;
   localparam logic [3:0] KIND_NUMBER = 4'd1;
   localparam logic [3:0] KIND_TRUE   = 4'd2;
   localparam logic [3:0] KIND_FALSE  = 4'd3;
   localparam logic [3:0] KIND_NULL   = 4'd4;
   localparam logic [3:0] KIND_LBRACE = 4'd5;
   localparam logic [3:0] KIND_RBRACE = 4'd6;
   localparam logic [3:0] KIND_LBRACK = 4'd7;
   localparam logic [3:0] KIND_RBRACK = 4'd8;
   localparam logic [3:0] KIND_COLON  = 4'd9;
   localparam logic [3:0] KIND_COMMA  = 4'd10;
   localparam logic [3:0] KIND_END    = 4'd11;

   // Error codes.
   localparam logic [1:0] ERR_NONE    = 2'd0;
   localparam logic [1:0] ERR_NUMBER  = 2'd1;
   localparam logic [1:0] ERR_KEYWORD = 2'd2;
   localparam logic [1:0] ERR_UNKNOWN = 2'd3;

   // Default depth of the result queue; it must hold at least two items.
   localparam int RESULT_DEPTH = 4;

   // One result item.
   typedef struct packed {
      logic [3:0] token_kind;
      logic [7:0] value_char;
      logic       has_char;
      logic       token_done;
      logic [1:0] error_code;
      logic       last;
   } result_type;

endpackage

`default_nettype wire

/* sv/jbt_lexer.sv */
// Lexer state machine: turns one item into zero, one or two result items.
`default_nettype none

module jbt_lexer (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step,
   input  wire logic                action,
   input  wire logic [7:0]          in_byte,
   output jbt_pkg::result_type      res0,
   output jbt_pkg::result_type      res1,
   output logic [1:0]               res_count
);

   typedef enum logic [3:0] {
      M_IDLE, M_STR, M_ESC, M_NSIGN, M_NZERO, M_NINT, M_NDOT,
      M_NFRAC, M_NEXP, M_NESIGN, M_NEDIG, M_KW
   } mode_type;

   // Outcome of treating a byte as the start of a new token.
   typedef struct packed {
      mode_type            mode;
      logic                kw;
      logic [1:0]          which;
      logic                emit;
      logic                err;
      jbt_pkg::result_type res;
   } start_type;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSL   = 8'h5c;
   localparam logic [7:0] CH_DOT   = 8'h2e;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_LOW_E = 8'h65;
   localparam logic [7:0] CH_UP_E  = 8'h45;
   localparam logic [7:0] CH_LOW_N = 8'h6e;
   localparam logic [7:0] CH_LOW_R = 8'h72;
   localparam logic [7:0] CH_LOW_T = 8'h74;
   localparam logic [7:0] CH_LOW_F = 8'h66;
   localparam logic [7:0] CH_LBRC  = 8'h7b;
   localparam logic [7:0] CH_RBRC  = 8'h7d;
   localparam logic [7:0] CH_LBRK  = 8'h5b;
   localparam logic [7:0] CH_RBRK  = 8'h5d;
   localparam logic [7:0] CH_COLON = 8'h3a;
   localparam logic [7:0] CH_COMMA = 8'h2c;

   mode_type   lex_mode_ff, lex_mode_in;
   logic [1:0] keyword_which_ff, keyword_which_in;
   logic [2:0] keyword_position_ff, keyword_position_in;
   logic       error_held_ff, error_held_in;

   function automatic jbt_pkg::result_type mk_res(logic [3:0] kind, logic [7:0] ch,
                                                  logic has, logic done, logic [1:0] err);
      jbt_pkg::result_type r;
      r.token_kind = kind;
      r.value_char = ch;
      r.has_char   = has;
      r.token_done = done;
      r.error_code = err;
      r.last       = 1'b0;
      return r;
   endfunction

   function automatic logic is_digit(logic [7:0] b);
      return (b >= CH_ZERO) && (b <= CH_NINE);
   endfunction

   // Keyword spelling: true, false, null.
   function automatic logic [7:0] kw_char(logic [1:0] w, logic [2:0] p);
      logic [7:0] c;
      c = 8'h00;
      case (w)
         2'd0: begin
            case (p)
               3'd0: c = 8'h74;
               3'd1: c = 8'h72;
               3'd2: c = 8'h75;
               3'd3: c = 8'h65;
               default: c = 8'h00;
            endcase
         end
         2'd1: begin
            case (p)
               3'd0: c = 8'h66;
               3'd1: c = 8'h61;
               3'd2: c = 8'h6c;
               3'd3: c = 8'h73;
               3'd4: c = 8'h65;
               default: c = 8'h00;
            endcase
         end
         default: begin
            case (p)
               3'd0: c = 8'h6e;
               3'd1: c = 8'h75;
               3'd2: c = 8'h6c;
               3'd3: c = 8'h6c;
               default: c = 8'h00;
            endcase
         end
      endcase
      return c;
   endfunction

   function automatic start_type start_fn(logic [7:0] b);
      start_type s;
      s.mode  = M_IDLE;
      s.kw    = 1'b0;
      s.which = 2'd0;
      s.emit  = 1'b0;
      s.err   = 1'b0;
      s.res   = mk_res(jbt_pkg::KIND_NUMBER, b, 1'b1, 1'b0, jbt_pkg::ERR_NONE);
      if (b == CH_SPACE || b == CH_LF || b == CH_CR || b == CH_TAB) begin
         s.emit = 1'b0;
      end else if (b == CH_QUOTE) begin
         s.mode = M_STR;
      end else if (b == CH_MINUS) begin
         s.emit = 1'b1;
         s.mode = M_NSIGN;
      end else if (is_digit(b)) begin
         s.emit = 1'b1;
         s.mode = (b == CH_ZERO) ? M_NZERO : M_NINT;
      end else if (b == CH_LOW_T || b == CH_LOW_F || b == CH_LOW_N) begin
         s.kw    = 1'b1;
         s.mode  = M_KW;
         s.which = (b == CH_LOW_T) ? 2'd0 : (b == CH_LOW_F) ? 2'd1 : 2'd2;
      end else begin
         s.emit = 1'b1;
         case (b)
            CH_LBRC:  s.res = mk_res(jbt_pkg::KIND_LBRACE, b, 1'b1, 1'b1, jbt_pkg::ERR_NONE);
            CH_RBRC:  s.res = mk_res(jbt_pkg::KIND_RBRACE, b, 1'b1, 1'b1, jbt_pkg::ERR_NONE);
            CH_LBRK:  s.res = mk_res(jbt_pkg::KIND_LBRACK, b, 1'b1, 1'b1, jbt_pkg::ERR_NONE);
            CH_RBRK:  s.res = mk_res(jbt_pkg::KIND_RBRACK, b, 1'b1, 1'b1, jbt_pkg::ERR_NONE);
            CH_COLON: s.res = mk_res(jbt_pkg::KIND_COLON, b, 1'b1, 1'b1, jbt_pkg::ERR_NONE);
            CH_COMMA: s.res = mk_res(jbt_pkg::KIND_COMMA, b, 1'b1, 1'b1, jbt_pkg::ERR_NONE);
            default: begin
               s.err = 1'b1;
               s.res = mk_res(jbt_pkg::KIND_STRING, 8'h00, 1'b0, 1'b0,
                              jbt_pkg::ERR_UNKNOWN);
            end
         endcase
      end
      return s;
   endfunction

   // One step of the lexer for the item held in the input register.
   always_comb begin
      jbt_pkg::result_type res [2];
      jbt_pkg::result_type num_res;
      logic [1:0] cnt;
      logic       need_start;
      logic       do_fail;
      logic [1:0] fail_code;
      logic [1:0] w;
      logic [2:0] klen;
      logic [2:0] pn;
      start_type  st;

      lex_mode_in         = lex_mode_ff;
      keyword_which_in    = keyword_which_ff;
      keyword_position_in = keyword_position_ff;
      error_held_in       = error_held_ff;
      res[0]     = mk_res(jbt_pkg::KIND_STRING, 8'h00, 1'b0, 1'b0, jbt_pkg::ERR_NONE);
      res[1]     = res[0];
      cnt        = 2'd0;
      need_start = 1'b0;
      do_fail    = 1'b0;
      fail_code  = jbt_pkg::ERR_NONE;
      w          = (keyword_which_ff == 2'd3) ? 2'd2 : keyword_which_ff;
      klen       = (w == 2'd1) ? 3'd5 : 3'd4;
      pn         = keyword_position_ff + 3'd1;
      st         = start_fn(in_byte);
      // A character that continues the current number.
      num_res    = mk_res(jbt_pkg::KIND_NUMBER, in_byte, 1'b1, 1'b0, jbt_pkg::ERR_NONE);

      if (step && !error_held_ff) begin
         if (action) begin
            // End of input: close what is open, then end token, or an error.
            case (lex_mode_ff)
               M_STR, M_ESC: begin
                  res[cnt[0]] = mk_res(jbt_pkg::KIND_STRING, 8'h00, 1'b0, 1'b1,
                                       jbt_pkg::ERR_NONE);
                  cnt = cnt + 2'd1;
               end
               M_NZERO, M_NINT, M_NFRAC, M_NEDIG: begin
                  res[cnt[0]] = mk_res(jbt_pkg::KIND_NUMBER, 8'h00, 1'b0, 1'b1,
                                       jbt_pkg::ERR_NONE);
                  cnt = cnt + 2'd1;
               end
               M_NSIGN, M_NDOT, M_NEXP, M_NESIGN: begin
                  do_fail   = 1'b1;
                  fail_code = jbt_pkg::ERR_NUMBER;
               end
               M_KW: begin
                  do_fail   = 1'b1;
                  fail_code = jbt_pkg::ERR_KEYWORD;
               end
               default: begin
                  cnt = cnt;
               end
            endcase
            if (!do_fail) begin
               res[cnt[0]] = mk_res(jbt_pkg::KIND_END, 8'h00, 1'b0, 1'b1,
                                    jbt_pkg::ERR_NONE);
               cnt = cnt + 2'd1;
               lex_mode_in         = M_IDLE;
               keyword_which_in    = 2'd0;
               keyword_position_in = 3'd0;
            end
         end else begin
            // A text byte.
            case (lex_mode_ff)
               M_STR: begin
                  if (in_byte == CH_QUOTE) begin
                     res[cnt[0]] = mk_res(jbt_pkg::KIND_STRING, 8'h00, 1'b0, 1'b1,
                                          jbt_pkg::ERR_NONE);
                     cnt = cnt + 2'd1;
                     lex_mode_in = M_IDLE;
                  end else if (in_byte == CH_BSL) begin
                     lex_mode_in = M_ESC;
                  end else begin
                     res[cnt[0]] = mk_res(jbt_pkg::KIND_STRING, in_byte, 1'b1, 1'b0,
                                          jbt_pkg::ERR_NONE);
                     cnt = cnt + 2'd1;
                  end
               end
               M_ESC: begin
                  res[cnt[0]] = mk_res(jbt_pkg::KIND_STRING,
                                       (in_byte == CH_LOW_N) ? CH_LF :
                                       (in_byte == CH_LOW_R) ? CH_CR :
                                       (in_byte == CH_LOW_T) ? CH_TAB : in_byte,
                                       1'b1, 1'b0, jbt_pkg::ERR_NONE);
                  cnt = cnt + 2'd1;
                  lex_mode_in = M_STR;
               end
               M_NSIGN: begin
                  if (is_digit(in_byte)) begin
                     res[cnt[0]] = num_res;
                     cnt = cnt + 2'd1;
                     lex_mode_in = (in_byte == CH_ZERO) ? M_NZERO : M_NINT;
                  end else begin
                     do_fail   = 1'b1;
                     fail_code = jbt_pkg::ERR_NUMBER;
                  end
               end
               M_NZERO, M_NINT: begin
                  if (is_digit(in_byte)) begin
                     if (lex_mode_ff == M_NZERO) begin
                        do_fail   = 1'b1;
                        fail_code = jbt_pkg::ERR_NUMBER;
                     end else begin
                        res[cnt[0]] = num_res;
                        cnt = cnt + 2'd1;
                     end
                  end else if (in_byte == CH_DOT) begin
                     res[cnt[0]] = num_res;
                     cnt = cnt + 2'd1;
                     lex_mode_in = M_NDOT;
                  end else if (in_byte == CH_LOW_E || in_byte == CH_UP_E) begin
                     res[cnt[0]] = num_res;
                     cnt = cnt + 2'd1;
                     lex_mode_in = M_NEXP;
                  end else begin
                     need_start = 1'b1;
                  end
               end
               M_NDOT: begin
                  if (is_digit(in_byte)) begin
                     res[cnt[0]] = num_res;
                     cnt = cnt + 2'd1;
                     lex_mode_in = M_NFRAC;
                  end else begin
                     do_fail   = 1'b1;
                     fail_code = jbt_pkg::ERR_NUMBER;
                  end
               end
               M_NFRAC: begin
                  if (is_digit(in_byte)) begin
                     res[cnt[0]] = num_res;
                     cnt = cnt + 2'd1;
                  end else if (in_byte == CH_LOW_E || in_byte == CH_UP_E) begin
                     res[cnt[0]] = num_res;
                     cnt = cnt + 2'd1;
                     lex_mode_in = M_NEXP;
                  end else begin
                     need_start = 1'b1;
                  end
               end
               M_NEXP: begin
                  if (in_byte == CH_PLUS || in_byte == CH_MINUS) begin
                     res[cnt[0]] = num_res;
                     cnt = cnt + 2'd1;
                     lex_mode_in = M_NESIGN;
                  end else if (is_digit(in_byte)) begin
                     res[cnt[0]] = num_res;
                     cnt = cnt + 2'd1;
                     lex_mode_in = M_NEDIG;
                  end else begin
                     do_fail   = 1'b1;
                     fail_code = jbt_pkg::ERR_NUMBER;
                  end
               end
               M_NESIGN: begin
                  if (is_digit(in_byte)) begin
                     res[cnt[0]] = num_res;
                     cnt = cnt + 2'd1;
                     lex_mode_in = M_NEDIG;
                  end else begin
                     do_fail   = 1'b1;
                     fail_code = jbt_pkg::ERR_NUMBER;
                  end
               end
               M_NEDIG: begin
                  if (is_digit(in_byte)) begin
                     res[cnt[0]] = num_res;
                     cnt = cnt + 2'd1;
                  end else begin
                     need_start = 1'b1;
                  end
               end
               M_KW: begin
                  if (keyword_position_ff < klen &&
                      in_byte == kw_char(w, keyword_position_ff)) begin
                     keyword_position_in = pn;
                     if (pn == klen) begin
                        res[cnt[0]] = mk_res(jbt_pkg::KIND_TRUE + {2'b00, w}, 8'h00,
                                             1'b0, 1'b1, jbt_pkg::ERR_NONE);
                        cnt = cnt + 2'd1;
                        lex_mode_in         = M_IDLE;
                        keyword_which_in    = 2'd0;
                        keyword_position_in = 3'd0;
                     end
                  end else begin
                     do_fail   = 1'b1;
                     fail_code = jbt_pkg::ERR_KEYWORD;
                  end
               end
               default: begin
                  lex_mode_in = M_IDLE;
                  need_start  = 1'b1;
               end
            endcase

            // A number ends here: close it, then treat the byte as a new start.
            // Idle and the unused mode codes only start a token.
            if (need_start) begin
               if (lex_mode_ff >= M_NZERO && lex_mode_ff <= M_NEDIG) begin
                  res[cnt[0]] = mk_res(jbt_pkg::KIND_NUMBER, 8'h00, 1'b0, 1'b1,
                                       jbt_pkg::ERR_NONE);
                  cnt = cnt + 2'd1;
               end
               lex_mode_in = st.mode;
               if (st.emit) begin
                  res[cnt[0]] = st.res;
                  cnt = cnt + 2'd1;
               end
               if (st.kw) begin
                  keyword_which_in    = st.which;
                  keyword_position_in = 3'd1;
               end
               if (st.err) begin
                  keyword_which_in    = 2'd0;
                  keyword_position_in = 3'd0;
                  error_held_in       = 1'b1;
               end
            end
         end

         // Errors emit one result and freeze the lexer until reset.
         if (do_fail) begin
            res[cnt[0]] = mk_res(jbt_pkg::KIND_STRING, 8'h00, 1'b0, 1'b0, fail_code);
            cnt = cnt + 2'd1;
            lex_mode_in         = M_IDLE;
            keyword_which_in    = 2'd0;
            keyword_position_in = 3'd0;
            error_held_in       = 1'b1;
         end

         if (cnt == 2'd1) begin
            res[0].last = 1'b1;
         end else if (cnt == 2'd2) begin
            res[1].last = 1'b1;
         end
      end

      res0      = res[0];
      res1      = res[1];
      res_count = cnt;
   end

   // Lexer state.
   always_ff @(posedge clock) begin
      if (reset) begin
         lex_mode_ff         <= M_IDLE;
         keyword_which_ff    <= 2'd0;
         keyword_position_ff <= 3'd0;
         error_held_ff       <= 1'b0;
      end else begin
         lex_mode_ff         <= lex_mode_in;
         keyword_which_ff    <= keyword_which_in;
         keyword_position_ff <= keyword_position_in;
         error_held_ff       <= error_held_in;
      end
   end

endmodule

`default_nettype wire

/* sv/jbt_out_fifo.sv */
// Result queue: takes up to two items per cycle and hands out one.
`default_nettype none

module jbt_out_fifo #(
   parameter int DEPTH = jbt_pkg::RESULT_DEPTH
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire jbt_pkg::result_type push0,
   input  wire jbt_pkg::result_type push1,
   input  wire logic [1:0]          push_count,
   input  wire logic                pop,
   output jbt_pkg::result_type      head,
   output logic                     not_empty,
   output logic                     room_two
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
   localparam logic [CW-1:0] ROOM_MAX = CW'(DEPTH - 2);

   jbt_pkg::result_type mem [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] wr_next;
   logic [CW-1:0] level;

   function automatic logic [AW-1:0] inc(logic [AW-1:0] p);
      return (p == LAST_IDX) ? '0 : p + AW'(1);
   endfunction

   // Pointer and fill-level bookkeeping.
   always_comb begin
      wr_next   = inc(wr_ptr_ff);
      not_empty = (count_ff != '0);
      head      = mem[rd_ptr_ff];
      level     = count_ff - CW'(pop);
      room_two  = (level <= ROOM_MAX);
      rd_ptr_in = pop ? inc(rd_ptr_ff) : rd_ptr_ff;
      case (push_count)
         2'd1:    wr_ptr_in = wr_next;
         2'd2:    wr_ptr_in = inc(wr_next);
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      count_in = level + CW'(push_count);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage writes.
   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         mem[wr_ptr_ff] <= push0;
      end
      if (push_count == 2'd2) begin
         mem[wr_next] <= push1;
      end
   end

endmodule

`default_nettype wire

/* sv/json_byte_tokenizer.sv */
// Top level of the streaming JSON byte tokenizer.
// An accepted item waits in the input register; its results reach rsp_ through the queue.
// Throughput: one item per cycle while the queue has room for two; results leave one per
// cycle from a small queue while rsp_ready is high, so two-result items are paced by rsp_.
// Reset is synchronous and active high: lexer returns to idle, errors clear, queue empties.
`default_nettype none

module json_byte_tokenizer #(
   parameter int RESULT_DEPTH = jbt_pkg::RESULT_DEPTH
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic       req_action,
   input  wire logic [7:0] req_in_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [3:0]      rsp_token_kind,
   output logic [7:0]      rsp_value_char,
   output logic            rsp_has_char,
   output logic            rsp_token_done,
   output logic [1:0]      rsp_error_code,
   output logic            rsp_last
);

   logic                in_valid_ff, in_valid_in;
   logic                action_ff;
   logic [7:0]          byte_ff;
   logic                step;
   logic                room_two;
   logic                pop;
   jbt_pkg::result_type res0, res1, head;
   logic [1:0]          res_count;

   // Input register: an item moves on when the queue has room for two results.
   always_comb begin
      step        = in_valid_ff && room_two;
      req_ready   = !in_valid_ff || step;
      in_valid_in = (req_valid && req_ready) ? 1'b1 : (step ? 1'b0 : in_valid_ff);
      pop         = rsp_valid && rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         action_ff <= req_action;
         byte_ff   <= req_in_byte;
      end
   end

   jbt_lexer u_lexer (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .action    (action_ff),
      .in_byte   (byte_ff),
      .res0      (res0),
      .res1      (res1),
      .res_count (res_count)
   );

   jbt_out_fifo #(
      .DEPTH (RESULT_DEPTH)
   ) u_out_fifo (
      .clock      (clock),
      .reset      (reset),
      .push0      (res0),
      .push1      (res1),
      .push_count (res_count),
      .pop        (pop),
      .head       (head),
      .not_empty  (rsp_valid),
      .room_two   (room_two)
   );

   // Result fields from the head of the queue.
   assign rsp_token_kind = head.token_kind;
   assign rsp_value_char = head.value_char;
   assign rsp_has_char   = head.has_char;
   assign rsp_token_done = head.token_done;
   assign rsp_error_code = head.error_code;
   assign rsp_last       = head.last;

endmodule

`default_nettype wire
